/* sv/rhms_pkg.sv */
package rhms_pkg;

  // Event kinds carried in the mode field
  localparam logic [2:0] EV_UPDATE    = 3'd0;
  localparam logic [2:0] EV_START     = 3'd1;
  localparam logic [2:0] EV_STOP      = 3'd2;
  localparam logic [2:0] EV_CALIBRATE = 3'd3;
  localparam logic [2:0] EV_CAL_DONE  = 3'd4;
  localparam logic [2:0] EV_RESET     = 3'd5;

  // System mode codes
  localparam logic [2:0] ST_OFFLINE     = 3'd0;
  localparam logic [2:0] ST_CONNECTED   = 3'd1;
  localparam logic [2:0] ST_READY       = 3'd2;
  localparam logic [2:0] ST_SERVOING    = 3'd3;
  localparam logic [2:0] ST_DEGRADED    = 3'd4;
  localparam logic [2:0] ST_CALIBRATING = 3'd5;
  localparam logic [2:0] ST_FAULT       = 3'd6;

  // Refusal reasons
  localparam logic [3:0] RC_NONE            = 4'd0;
  localparam logic [3:0] RC_START_NOT_READY = 4'd1;
  localparam logic [3:0] RC_START_STALE     = 4'd2;
  localparam logic [3:0] RC_START_COND_LOST = 4'd3;
  localparam logic [3:0] RC_STOP_NOT_ACTIVE = 4'd4;
  localparam logic [3:0] RC_CAL_NOT_READY   = 4'd5;
  localparam logic [3:0] RC_CAL_NO_LINK     = 4'd6;
  localparam logic [3:0] RC_CAL_NO_STREAM   = 4'd7;
  localparam logic [3:0] RC_RESET_NO_FAULT  = 4'd8;

  // Health flags of one event
  typedef struct packed {
    logic       cmd_link_ok;
    logic       motion_topic_fresh;
    logic       motion_link_up;
    logic       cmd_tcp_up;
    logic       heartbeat_recent;
    logic       heartbeat_motion_on;
    logic       program_is_ready;
    logic       sensor_streaming;
    logic       tool_in_sync;
    logic       ctrl_loaded;
    logic [1:0] fault_bits;
  } flags_t;

  // Supervisor state
  typedef struct packed {
    logic [2:0] mode;
    logic       servo_wanted;
    logic       calib_active;
  } sup_state_t;

  // One result item
  typedef struct packed {
    logic [2:0] sys_state;
    logic       accepted;
    logic [3:0] refuse_code;
    logic       zero_ok;
  } result_t;

endpackage

/* sv/rhms_eval.sv */
module rhms_eval
  import rhms_pkg::*;
(
  input  logic [2:0] ev,
  input  flags_t     flags,
  input  sup_state_t cur,
  output sup_state_t nxt,
  output result_t    res
);

  logic link_good;
  logic ready_ok;
  logic residue;
  logic motion_ok;
  logic acc;
  logic [3:0] code;

  // Link and readiness checks
  assign link_good = flags.cmd_link_ok |
                     (flags.motion_topic_fresh & flags.motion_link_up & flags.cmd_tcp_up);
  assign ready_ok  = link_good & flags.program_is_ready & flags.sensor_streaming &
                     flags.tool_in_sync & flags.ctrl_loaded;
  assign motion_ok = flags.motion_topic_fresh & flags.motion_link_up;
  // Motion fault left over from a finished session while idle
  assign residue   = ~cur.servo_wanted & ~cur.calib_active &
                     flags.heartbeat_recent & ~flags.heartbeat_motion_on;

  // Next state and request decision
  always_comb begin
    nxt  = cur;
    acc  = 1'b1;
    code = RC_NONE;
    unique case (ev)
      EV_UPDATE: begin
        priority if (flags.fault_bits[0] || (flags.fault_bits[1] && !residue)) begin
          nxt.mode         = ST_FAULT;
          nxt.servo_wanted = 1'b0;
          nxt.calib_active = 1'b0;
        end else if (cur.mode == ST_FAULT) begin
          nxt.mode = ST_FAULT;
        end else if (cur.calib_active) begin
          if (link_good && motion_ok && flags.sensor_streaming) begin
            nxt.mode = ST_CALIBRATING;
          end else begin
            nxt.mode         = ST_FAULT;
            nxt.calib_active = 1'b0;
          end
        end else if (cur.servo_wanted) begin
          nxt.mode = (ready_ok && motion_ok) ? ST_SERVOING : ST_DEGRADED;
        end else if (!link_good) begin
          nxt.mode = ST_OFFLINE;
        end else if (ready_ok) begin
          nxt.mode = ST_READY;
        end else begin
          nxt.mode = ST_CONNECTED;
        end
      end
      EV_START: begin
        priority if (cur.mode != ST_READY)   code = RC_START_NOT_READY;
        else if (!flags.motion_topic_fresh)  code = RC_START_STALE;
        else if (!ready_ok)                  code = RC_START_COND_LOST;
        else                                 nxt.servo_wanted = 1'b1;
      end
      EV_STOP: begin
        if (cur.mode != ST_SERVOING && cur.mode != ST_DEGRADED) code = RC_STOP_NOT_ACTIVE;
        else nxt.servo_wanted = 1'b0;
      end
      EV_CALIBRATE: begin
        priority if (cur.mode != ST_READY)  code = RC_CAL_NOT_READY;
        else if (!motion_ok)                code = RC_CAL_NO_LINK;
        else if (!flags.sensor_streaming)   code = RC_CAL_NO_STREAM;
        else                                nxt.calib_active = 1'b1;
      end
      EV_CAL_DONE: begin
        nxt.calib_active = 1'b0;
      end
      EV_RESET: begin
        if (cur.mode != ST_FAULT) code = RC_RESET_NO_FAULT;
        else nxt.mode = ST_OFFLINE;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  // Assemble the result
  always_comb begin
    res.sys_state   = nxt.mode;
    res.accepted    = acc & (code == RC_NONE);
    res.refuse_code = code;
    res.zero_ok     = (nxt.mode == ST_CONNECTED) || (nxt.mode == ST_READY);
  end

endmodule

/* sv/robot_health_mode_supervisor_unit.sv */
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_stall  | mode, cmd_link_ok .. ctrl_loaded, fault_bits
// out     | out_valid / out_stall| sys_state, accepted, refuse_code, zero_ok
//
// One event per cycle sustained while out_stall is low; each event passes
// from input transfer through the input register, then the result register.
// The mode and flag registers update in the cycle the event moves to the
// result register, so the next event sees them at once.
// rst is synchronous: mode goes to offline, flags clear, both stages empty.
// A stalled result holds; the input register then fills and in_stall rises.
module robot_health_mode_supervisor_unit
  import rhms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] mode,
  input  logic       cmd_link_ok,
  input  logic       motion_topic_fresh,
  input  logic       motion_link_up,
  input  logic       cmd_tcp_up,
  input  logic       heartbeat_recent,
  input  logic       heartbeat_motion_on,
  input  logic       program_is_ready,
  input  logic       sensor_streaming,
  input  logic       tool_in_sync,
  input  logic       ctrl_loaded,
  input  logic [1:0] fault_bits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] sys_state,
  output logic       accepted,
  output logic [3:0] refuse_code,
  output logic       zero_ok
);

  logic       in_q_valid;
  logic [2:0] ev_q;
  flags_t     flags_q;
  sup_state_t st;
  sup_state_t st_next;
  result_t    res_next;
  result_t    res;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // Handshake control
  assign out_free = ~out_valid | ~out_stall;
  assign advance  = in_q_valid & out_free;
  assign in_stall = in_q_valid & ~out_free;
  assign in_take  = in_valid & ~in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_q    <= mode;
      flags_q <= '{cmd_link_ok, motion_topic_fresh, motion_link_up, cmd_tcp_up,
                   heartbeat_recent, heartbeat_motion_on, program_is_ready,
                   sensor_streaming, tool_in_sync, ctrl_loaded, fault_bits};
    end
  end

  rhms_eval u_eval (
    .ev    (ev_q),
    .flags (flags_q),
    .cur   (st),
    .nxt   (st_next),
    .res   (res_next)
  );

  // Supervisor state, advance on each event
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{ST_OFFLINE, 1'b0, 1'b0};
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: load on advance, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign sys_state   = res.sys_state;
  assign accepted    = res.accepted;
  assign refuse_code = res.refuse_code;
  assign zero_ok     = res.zero_ok;

`ifndef SYNTHESIS
  // Fault mode never keeps a running calibration
  a_fault_flags_clear: assert property (@(posedge clk) disable iff (rst)
    st.mode == ST_FAULT |-> !st.calib_active)
    else $error("fault mode with calibration flag set");

  // A refused request is never reported as accepted
  a_refuse_not_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && refuse_code != RC_NONE |-> !accepted)
    else $error("refusal code with accepted set");

  // State moves only when an event leaves the input register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("supervisor state changed without an event");

  // Reset empties the input and result stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_q_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
